// ===== design/tefb_pkg.sv =====
`timescale 1ns / 1ps

package tefb_pkg;

  localparam int PANEL_WIDTH  = 600;
  localparam int PANEL_HEIGHT = 448;
  localparam int BUF_BYTES    = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
  localparam int ADDR_W       = $clog2(BUF_BYTES);

  localparam int REQ_W      = 2;
  localparam int COORD_W    = 11;
  localparam int DIM_W      = 12;
  localparam int PROD_W     = COORD_W + DIM_W;
  localparam int COLOR_W    = 16;
  localparam int INDEX_W    = 16;
  localparam int PIX_W      = 8;
  localparam int ROT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_DRAW = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FILL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_CODE   = 2'd3;

  localparam logic [ROT_W-1:0]   ROT_RESET   = 2'd0;
  localparam logic [COLOR_W-1:0] WHITE_RESET = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BLACK_RESET = 16'h0000;
  localparam logic [COLOR_W-1:0] RED_RESET   = 16'hF800;

  localparam logic [COLOR_W-1:0] MASK_R    = 16'hF100;
  localparam logic [COLOR_W-1:0] MASK_G    = 16'h07E0;
  localparam logic [COLOR_W-1:0] MASK_B    = 16'h001F;
  localparam logic [COLOR_W-1:0] RED_HALF  = 16'(32'hF100 / 2);
  localparam logic [9:0]         SUM_LIMIT = 10'(3 * 255 / 2);

  localparam logic [3:0] PIX_BLACK = 4'h0;
  localparam logic [3:0] PIX_RED   = 4'h4;
  localparam logic [3:0] PIX_WHITE = 4'h3;

  typedef enum logic [1:0] {
    CLS_WHITE,
    CLS_BLACK,
    CLS_RED
  } cls_t;

  function automatic cls_t classify(input logic [COLOR_W-1:0] c,
                                    input logic [COLOR_W-1:0] wc,
                                    input logic [COLOR_W-1:0] bc,
                                    input logic [COLOR_W-1:0] rc);
    logic [9:0] sum;
    cls_t       cls;
    sum = 10'((c & MASK_R) >> 11) + 10'((c & MASK_G) >> 5) + 10'(c & MASK_B);
    if (c == wc) cls = CLS_WHITE;
    else if (c == bc) cls = CLS_BLACK;
    else if (c == rc) cls = CLS_RED;
    else if ((c & MASK_R) > RED_HALF) cls = CLS_RED;
    else if (sum < SUM_LIMIT) cls = CLS_BLACK;
    else cls = CLS_WHITE;
    return cls;
  endfunction

  // black wins over red
  function automatic logic [3:0] pix_code(input logic b, input logic r);
    logic [3:0] code;
    if (b) code = PIX_BLACK;
    else if (r) code = PIX_RED;
    else code = PIX_WHITE;
    return code;
  endfunction

endpackage

// ===== design/tefb_req_if.sv =====
`timescale 1ns / 1ps

interface tefb_req_if import tefb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [COLOR_W-1:0]        pixel_color;
  logic [INDEX_W-1:0]        byte_index;

  modport source (output valid, req_type, pos_x, pos_y, pixel_color, byte_index,
                  input ready);
  modport sink (input valid, req_type, pos_x, pos_y, pixel_color, byte_index,
                output ready);
endinterface

// ===== design/tefb_rsp_if.sv =====
`timescale 1ns / 1ps

interface tefb_rsp_if import tefb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] packed_pixels;
  logic             last_of_run;

  modport source (output valid, packed_pixels, last_of_run, input ready);
  modport sink (input valid, packed_pixels, last_of_run, output ready);
endinterface

// ===== design/tricolor_epaper_framebuffer_unit.sv =====
`timescale 1ns / 1ps

// Three-color e-paper frame buffer: black and red bit planes share one RAM word
// per buffer byte ({black, red}), with a registered read port and one write port.
// After reset the unit sweeps the whole buffer to white, one byte per cycle
// (BUF_BYTES bytes, 33600 for a 600x448 panel) and holds req.ready low meanwhile.
// A draw steps through accept, address and RAM read, then modify and write back.
// A fill is accepted and then runs the same sweep as after reset.
// A read loads the addressed byte and then gives four output transfers.
// Items are handled one at a time; config writes are taken on any cycle, but only
// while the unit is idle do they give defined results.
module tricolor_epaper_framebuffer_unit import tefb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tefb_req_if.sink              req,
  tefb_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DRAW_ADDR,
    ST_DRAW_WRITE,
    ST_READ_LOAD,
    ST_READ_OUT
  } state_t;

  state_t               state;
  logic [ROT_W-1:0]     rotation;
  logic [COLOR_W-1:0]   white_code;
  logic [COLOR_W-1:0]   black_code;
  logic [COLOR_W-1:0]   red_code;
  logic [ADDR_W-1:0]    fill_pointer;
  logic [2*PIX_W-1:0]   fill_word;
  logic [COORD_W-1:0]   px_q;
  logic [COORD_W-1:0]   py_q;
  cls_t                 cls_q;
  logic [ADDR_W-1:0]    draw_addr;
  logic                 rd_blank;
  logic [PIX_W-1:0]     rd_b;
  logic [PIX_W-1:0]     rd_r;
  logic [1:0]           out_cnt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [2*PIX_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [2*PIX_W-1:0]   ram_rdata;

  logic                 req_xfer;
  cls_t                 in_cls;
  logic [DIM_W-1:0]     xu;
  logic [DIM_W-1:0]     yu;
  logic [DIM_W-1:0]     rot_w;
  logic [DIM_W-1:0]     rot_h;
  logic                 in_bounds;
  logic [DIM_W-1:0]     px_n;
  logic [DIM_W-1:0]     py_n;
  logic [PROD_W-1:0]    row_prod;
  logic [PROD_W-1:0]    idx_full;
  logic                 idx_ok;
  logic                 rd_idx_ok;
  logic [PIX_W-1:0]     pix_mask;
  logic [PIX_W-1:0]     new_b;
  logic [PIX_W-1:0]     new_r;
  logic [PIX_W-1:0]     sh_b;
  logic [PIX_W-1:0]     sh_r;

  assign req.ready = (state == ST_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign in_cls    = classify(req.pixel_color, white_code, black_code, red_code);

  // Bounds check and rotation of the incoming point
  always_comb begin
    xu    = {1'b0, req.pos_x};
    yu    = {1'b0, req.pos_y};
    rot_w = rotation[0] ? DIM_W'(PANEL_HEIGHT) : DIM_W'(PANEL_WIDTH);
    rot_h = rotation[0] ? DIM_W'(PANEL_WIDTH) : DIM_W'(PANEL_HEIGHT);
    in_bounds = !req.pos_x[COORD_W-1] && !req.pos_y[COORD_W-1]
                && (xu < rot_w) && (yu < rot_h);
    case (rotation)
      2'd1: begin
        px_n = DIM_W'(PANEL_WIDTH - 1) - yu;
        py_n = xu;
      end
      2'd2: begin
        px_n = DIM_W'(PANEL_WIDTH - 1) - xu;
        py_n = DIM_W'(PANEL_HEIGHT - 1) - yu;
      end
      2'd3: begin
        px_n = yu;
        py_n = DIM_W'(PANEL_HEIGHT - 1) - xu;
      end
      default: begin
        px_n = xu;
        py_n = yu;
      end
    endcase
  end

  // Byte address of the rotated point
  always_comb begin
    row_prod = PROD_W'(py_q) * PROD_W'(PANEL_WIDTH);
    idx_full = (row_prod >> 3) + PROD_W'(px_q >> 3);
    idx_ok   = (32'(idx_full) < BUF_BYTES);
  end

  assign rd_idx_ok = (32'(req.byte_index) < BUF_BYTES);

  // Read-modify-write of one pixel
  always_comb begin
    pix_mask = PIX_W'(8'h80) >> px_q[2:0];
    new_b = ram_rdata[2*PIX_W-1:PIX_W] & ~pix_mask;
    new_r = ram_rdata[PIX_W-1:0] & ~pix_mask;
    if (cls_q == CLS_BLACK) new_b = new_b | pix_mask;
    if (cls_q == CLS_RED) new_r = new_r | pix_mask;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_pointer;
    ram_wdata = fill_word;
    ram_raddr = ADDR_W'(req.byte_index);
    case (state)
      ST_SWEEP: begin
        ram_we = 1'b1;
      end
      ST_DRAW_ADDR: begin
        ram_raddr = ADDR_W'(idx_full);
      end
      ST_DRAW_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = draw_addr;
        ram_wdata = {new_b, new_r};
      end
      default: begin
      end
    endcase
  end

  tefb_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (BUF_BYTES)
  ) u_planes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output: two pixels per transfer, leftmost pixel in the high nibble
  always_comb begin
    sh_b = rd_b << {out_cnt, 1'b0};
    sh_r = rd_r << {out_cnt, 1'b0};
  end

  assign rsp.valid         = (state == ST_READ_OUT);
  assign rsp.packed_pixels = {pix_code(sh_b[PIX_W-1], sh_r[PIX_W-1]),
                              pix_code(sh_b[PIX_W-2], sh_r[PIX_W-2])};
  assign rsp.last_of_run   = (out_cnt == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      fill_pointer <= '0;
      fill_word    <= '0;
      out_cnt      <= '0;
      rotation     <= ROT_RESET;
      white_code   <= WHITE_RESET;
      black_code   <= BLACK_RESET;
      red_code     <= RED_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROTATION:   rotation   <= cfg_data[ROT_W-1:0];
          CFG_WHITE_CODE: white_code <= cfg_data[COLOR_W-1:0];
          CFG_BLACK_CODE: black_code <= cfg_data[COLOR_W-1:0];
          CFG_RED_CODE:   red_code   <= cfg_data[COLOR_W-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        ST_SWEEP: begin
          if (32'(fill_pointer) == BUF_BYTES - 1) begin
            fill_pointer <= '0;
            state        <= ST_IDLE;
          end else begin
            fill_pointer <= fill_pointer + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req_xfer) begin
            case (req.req_type)
              REQ_DRAW: begin
                px_q  <= px_n[COORD_W-1:0];
                py_q  <= py_n[COORD_W-1:0];
                cls_q <= in_cls;
                if (in_bounds) state <= ST_DRAW_ADDR;
              end
              REQ_FILL: begin
                fill_word <= {{PIX_W{in_cls == CLS_BLACK}}, {PIX_W{in_cls == CLS_RED}}};
                state     <= ST_SWEEP;
              end
              REQ_READ: begin
                rd_blank <= !rd_idx_ok;
                state    <= ST_READ_LOAD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DRAW_ADDR: begin
          draw_addr <= ADDR_W'(idx_full);
          state     <= idx_ok ? ST_DRAW_WRITE : ST_IDLE;
        end
        ST_DRAW_WRITE: begin
          state <= ST_IDLE;
        end
        ST_READ_LOAD: begin
          rd_b    <= rd_blank ? '0 : ram_rdata[2*PIX_W-1:PIX_W];
          rd_r    <= rd_blank ? '0 : ram_rdata[PIX_W-1:0];
          out_cnt <= '0;
          state   <= ST_READ_OUT;
        end
        ST_READ_OUT: begin
          if (rsp.ready) begin
            out_cnt <= out_cnt + 1'b1;
            if (out_cnt == 2'd3) state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(fill_pointer) < BUF_BYTES)
    else $error("fill pointer left the buffer");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("input taken while read output is pending");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.last_of_run) |=> !rsp.valid)
    else $error("output continued past last transfer of a read");

  a_draw_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW_WRITE) |-> (32'(ram_waddr) < BUF_BYTES) && ram_we)
    else $error("draw write outside the buffer");

endmodule

// ===== design/tefb_ram.sv =====
`timescale 1ns / 1ps

module tefb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
